[hdl/k_nearest_neighbour_selector_core_defines.svh]
// ----------------------------------------------------------------------------
// k_nearest_neighbour_selector_core_defines
// Assertion macros used by the selector core RTL. Define NO_ASSERTIONS to drop
// every check from the build.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_NEIGHBOUR_SELECTOR_CORE_DEFINES_SVH
`define K_NEAREST_NEIGHBOUR_SELECTOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check outside reset
`define KNN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define KNN_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define KNN_ASSERT(lbl, prop, msg)
`define KNN_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hdl/knn_pkg.sv]
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, codes, types and reset values of the k-nearest-neighbour
// selector.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

   localparam int MAX_NEIGHBOURS_DEF = 32;
   localparam int COORD_BITS_DEF     = 24;
   localparam int INDEX_BITS_DEF     = 20;

   localparam int DIST_W     = 52;
   localparam int OUT_IDX_W  = 20;
   localparam int SLOT_NUM_W = 5;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int KIND_W     = 2;

   localparam logic [DIST_W-1:0]  DIST_MAX          = '1;
   localparam logic [COUNT_W-1:0] COUNT_RESET       = 6'd20;
   localparam logic               SKIP_RESET        = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_QUERY     = 2'd0,
      KIND_CANDIDATE = 2'd1,
      KIND_FINISH    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NEIGHBOUR_COUNT = 2'd0,
      REG_RADIUS_SQUARED  = 2'd1,
      REG_SKIP_BOUNDARY   = 2'd2
   } csr_reg_type;

   typedef enum logic {
      ST_RUN  = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic rotate;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hdl/knn_if.sv]
// ----------------------------------------------------------------------------
// knn_if
// Valid/ready channels of the selector: query, candidate and finish input, neighbour
// results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface knn_req_if #(
   parameter int COORD_BITS = knn_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = knn_pkg::INDEX_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [knn_pkg::KIND_W-1:0]          kind;
   logic signed [COORD_BITS-1:0]        x_coord;
   logic signed [COORD_BITS-1:0]        y_coord;
   logic signed [COORD_BITS-1:0]        z_coord;
   logic [INDEX_BITS-1:0]               point_index;
   logic                                on_boundary;

   modport source (output valid, kind, x_coord, y_coord, z_coord, point_index, on_boundary,
                   input ready);
   modport sink   (input valid, kind, x_coord, y_coord, z_coord, point_index, on_boundary,
                   output ready);
endinterface

interface knn_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [knn_pkg::SLOT_NUM_W-1:0]     slot_number;
   logic [knn_pkg::OUT_IDX_W-1:0]      neighbour_index;
   logic [knn_pkg::DIST_W-1:0]         neighbour_distance_sq;
   logic                               slot_filled;
   logic                               list_incomplete;
   logic                               last_of_list;

   modport source (output valid, slot_number, neighbour_index, neighbour_distance_sq,
                   slot_filled, list_incomplete, last_of_list, input ready);
   modport sink   (input valid, slot_number, neighbour_index, neighbour_distance_sq,
                   slot_filled, list_incomplete, last_of_list, output ready);
endinterface

interface knn_csr_if;
   logic                              valid;
   logic                              ready;
   logic [knn_pkg::CSR_IDX_W-1:0]     index;
   logic [knn_pkg::DIST_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/knn_front.sv]
// ----------------------------------------------------------------------------
// knn_front
// Query point registers and the four-stage squared distance pipeline that
// feeds the insertion chain in item order.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_front #(
   parameter int COORD_BITS = knn_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = knn_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          acc,
   input  knn_pkg::kind_type             kind,
   input  logic signed [COORD_BITS-1:0]  x_coord,
   input  logic signed [COORD_BITS-1:0]  y_coord,
   input  logic signed [COORD_BITS-1:0]  z_coord,
   input  logic [INDEX_BITS-1:0]         point_index,
   input  logic                          on_boundary,
   input  logic                          skip_boundary_pairs,
   input  logic [knn_pkg::DIST_W-1:0]    radius_squared,
   output logic                          p_valid,
   output knn_pkg::kind_type             p_kind,
   output logic [knn_pkg::DIST_W-1:0]    p_dist,
   output logic [INDEX_BITS-1:0]         p_index,
   output logic                          p_keep
);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int SUM_W  = (SQ_W > knn_pkg::DIST_W) ? SQ_W : knn_pkg::DIST_W + 1;
   localparam int DW     = knn_pkg::DIST_W;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic [INDEX_BITS-1:0]        qidx_ff;
   logic                         qbnd_ff;

   logic signed [DIFF_W-1:0]     dx, dy, dz;
   logic [COORD_BITS-1:0]        mx_in, my_in, mz_in;
   logic                         s1_valid_in, s1_keep_in;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   knn_pkg::kind_type            s1_kind_ff, s2_kind_ff, s3_kind_ff, s4_kind_ff;
   logic [INDEX_BITS-1:0]        s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic                         s1_keep_ff, s2_keep_ff, s3_keep_ff, s4_keep_ff;
   logic [COORD_BITS-1:0]        s1_mx_ff, s1_my_ff, s1_mz_ff;
   logic [SQ_W-1:0]              s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic [DW-1:0]                s3_pxy_ff, s3_pz_ff;
   logic [DW-1:0]                s4_dist_ff;

   logic [SQ_W-1:0]              sqx_in, sqy_in, sqz_in;
   logic [SUM_W-1:0]             wx, wy, wz;
   logic [DW-1:0]                satx, saty, satz;
   logic [DW:0]                  sum_xy, sum_all;
   logic [DW-1:0]                pxy_in, dist_in;
   logic                         keep_in;

   // query point: loaded at the transfer of a query item
   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff   <= '0;
         qy_ff   <= '0;
         qz_ff   <= '0;
         qidx_ff <= '0;
         qbnd_ff <= 1'b0;
      end else if (acc && kind == knn_pkg::KIND_QUERY) begin
         qx_ff   <= x_coord;
         qy_ff   <= y_coord;
         qz_ff   <= z_coord;
         qidx_ff <= point_index;
         qbnd_ff <= on_boundary;
      end
   end

   // stage 1: exact differences and magnitudes, boundary-pair drop
   always_comb begin
      dx = DIFF_W'(x_coord) - DIFF_W'(qx_ff);
      dy = DIFF_W'(y_coord) - DIFF_W'(qy_ff);
      dz = DIFF_W'(z_coord) - DIFF_W'(qz_ff);
      mx_in = dx[DIFF_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      my_in = dy[DIFF_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      mz_in = dz[DIFF_W-1] ? COORD_BITS'(-dz) : COORD_BITS'(dz);
      s1_valid_in = acc && (kind == knn_pkg::KIND_QUERY || kind == knn_pkg::KIND_CANDIDATE ||
                            kind == knn_pkg::KIND_FINISH);
      s1_keep_in  = !(skip_boundary_pairs && qbnd_ff && on_boundary &&
                      (point_index != qidx_ff));
   end

   // stage 2: squares
   always_comb begin
      sqx_in = SQ_W'(s1_mx_ff) * SQ_W'(s1_mx_ff);
      sqy_in = SQ_W'(s1_my_ff) * SQ_W'(s1_my_ff);
      sqz_in = SQ_W'(s1_mz_ff) * SQ_W'(s1_mz_ff);
   end

   // stage 3: saturate the squares and add the first two
   always_comb begin
      wx = SUM_W'(s2_sqx_ff);
      wy = SUM_W'(s2_sqy_ff);
      wz = SUM_W'(s2_sqz_ff);
      satx = (wx > SUM_W'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : DW'(wx);
      saty = (wy > SUM_W'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : DW'(wy);
      satz = (wz > SUM_W'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : DW'(wz);
      sum_xy = {1'b0, satx} + {1'b0, saty};
      pxy_in = sum_xy[DW] ? knn_pkg::DIST_MAX : sum_xy[DW-1:0];
   end

   // stage 4: final sum and radius test
   always_comb begin
      sum_all = {1'b0, s3_pxy_ff} + {1'b0, s3_pz_ff};
      dist_in = sum_all[DW] ? knn_pkg::DIST_MAX : sum_all[DW-1:0];
      keep_in = s3_keep_ff && (dist_in <= radius_squared);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff <= kind;
         s1_idx_ff  <= point_index;
         s1_keep_ff <= s1_keep_in;
         s1_mx_ff   <= mx_in;
         s1_my_ff   <= my_in;
         s1_mz_ff   <= mz_in;

         s2_kind_ff <= s1_kind_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_keep_ff <= s1_keep_ff;
         s2_sqx_ff  <= sqx_in;
         s2_sqy_ff  <= sqy_in;
         s2_sqz_ff  <= sqz_in;

         s3_kind_ff <= s2_kind_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_keep_ff <= s2_keep_ff;
         s3_pxy_ff  <= pxy_in;
         s3_pz_ff   <= satz;

         s4_kind_ff <= s3_kind_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_keep_ff <= keep_in;
         s4_dist_ff <= dist_in;
      end
   end

   assign p_valid = s4_valid_ff;
   assign p_kind  = s4_kind_ff;
   assign p_dist  = s4_dist_ff;
   assign p_index = s4_idx_ff;
   assign p_keep  = s4_keep_ff;

endmodule

`default_nettype wire

[hdl/knn_cell.sv]
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted neighbour list. Compares the broadcast candidate,
// takes it, shifts in its left neighbour, or rotates in its right neighbour
// while the list is read out; a query item clears it.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_cell #(
   parameter int INDEX_BITS = knn_pkg::INDEX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  knn_pkg::cell_ctrl_type      ctrl,
   input  logic                        active,
   input  logic                        wrap,
   input  logic                        hit_in,
   output logic                        hit_out,
   input  logic [knn_pkg::DIST_W-1:0]  cand_dist,
   input  logic [INDEX_BITS-1:0]       cand_index,
   input  logic                        left_valid,
   input  logic [knn_pkg::DIST_W-1:0]  left_dist,
   input  logic [INDEX_BITS-1:0]       left_index,
   input  logic                        right_valid,
   input  logic [knn_pkg::DIST_W-1:0]  right_dist,
   input  logic [INDEX_BITS-1:0]       right_index,
   input  logic                        head_valid,
   input  logic [knn_pkg::DIST_W-1:0]  head_dist,
   input  logic [INDEX_BITS-1:0]       head_index,
   output logic                        slot_valid,
   output logic [knn_pkg::DIST_W-1:0]  slot_dist,
   output logic [INDEX_BITS-1:0]       slot_index
);

   logic                        valid_ff, valid_in;
   logic [knn_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [INDEX_BITS-1:0]       index_ff, index_in;
   logic                        take;

   // an empty slot counts as farther than any candidate
   assign take    = active && (!valid_ff || cand_dist < dist_ff);
   assign hit_out = hit_in || take;

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      index_in = index_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert && active) begin
         priority if (hit_in) begin
            valid_in = left_valid;
            dist_in  = left_dist;
            index_in = left_index;
         end else if (take) begin
            valid_in = 1'b1;
            dist_in  = cand_dist;
            index_in = cand_index;
         end
      end else if (ctrl.rotate && active) begin
         priority if (wrap) begin
            valid_in = head_valid;
            dist_in  = head_dist;
            index_in = head_index;
         end else begin
            valid_in = right_valid;
            dist_in  = right_dist;
            index_in = right_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      index_ff <= index_in;
   end

   assign slot_valid = valid_ff;
   assign slot_dist  = dist_ff;
   assign slot_index = index_ff;

endmodule

`default_nettype wire

[hdl/k_nearest_neighbour_selector_core.sv]
// A finish item's results leave after it passes the distance pipeline, one per cycle with the sink ready.
// Throughput: items transfer one per cycle through the distance pipeline while no list is read out.
// A finish stops the input once it leaves the four-stage distance pipeline and holds it
// until all K slots (neighbour_count clamped to 1..MAX_NEIGHBOURS) have been emitted.
// Results are emitted by rotating the slot cells, one slot per cycle with the sink ready.
// Reset: empty list, query at origin, count 20, full radius, boundary-pair skip on.
// ----------------------------------------------------------------------------
// k_nearest_neighbour_selector_core
// Keeps the K nearest candidates to a query point in a chain of slot cells
// sorted by squared distance, and emits the list on a finish item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_nearest_neighbour_selector_core_defines.svh"

module k_nearest_neighbour_selector_core #(
   parameter int MAX_NEIGHBOURS = knn_pkg::MAX_NEIGHBOURS_DEF,
   parameter int COORD_BITS     = knn_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS     = knn_pkg::INDEX_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   knn_req_if.sink     req_ch,
   knn_rsp_if.source   rsp_ch,
   knn_csr_if.sink     csr_ch
);

   localparam int SLOT_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int IDX_EXT_W = (INDEX_BITS > knn_pkg::OUT_IDX_W) ? INDEX_BITS
                                                                 : knn_pkg::OUT_IDX_W;
   localparam int DW = knn_pkg::DIST_W;

   // configuration
   logic [knn_pkg::COUNT_W-1:0] count_ff;
   logic [DW-1:0]               radius_ff;
   logic                        skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= knn_pkg::COUNT_RESET;
         radius_ff <= knn_pkg::DIST_MAX;
         skip_ff   <= knn_pkg::SKIP_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            knn_pkg::REG_NEIGHBOUR_COUNT: count_ff  <= csr_ch.data[knn_pkg::COUNT_W-1:0];
            knn_pkg::REG_RADIUS_SQUARED:  radius_ff <= csr_ch.data;
            knn_pkg::REG_SKIP_BOUNDARY:   skip_ff   <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // active count, clamped to 1..MAX_NEIGHBOURS
   logic [7:0]        cnt_ext, k_eff;
   logic [SLOT_W-1:0] last_slot;

   always_comb begin
      cnt_ext = 8'(count_ff);
      priority if (cnt_ext == 8'd0) begin
         k_eff = 8'd1;
      end else if (cnt_ext > 8'(MAX_NEIGHBOURS)) begin
         k_eff = 8'(MAX_NEIGHBOURS);
      end else begin
         k_eff = cnt_ext;
      end
      last_slot = SLOT_W'(k_eff - 8'd1);
   end

   // control
   knn_pkg::state_type     state_ff, state_in;
   logic                   adv, emit_step, out_load, emit_last;
   logic                   acc;
   logic                   p_valid, p_keep;
   knn_pkg::kind_type      p_kind;
   logic [DW-1:0]          p_dist;
   logic [INDEX_BITS-1:0]  p_index;
   knn_pkg::cell_ctrl_type ctrl;
   logic [SLOT_W-1:0]      cnt_ff;
   logic                   incomplete_ff;
   logic                   rsp_valid_ff;

   assign acc       = req_ch.valid && req_ch.ready;
   assign out_load  = !rsp_valid_ff || rsp_ch.ready;
   assign emit_last = (cnt_ff == last_slot);

   knn_front #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .adv                 (adv),
      .acc                 (acc),
      .kind                (knn_pkg::kind_type'(req_ch.kind)),
      .x_coord             (req_ch.x_coord),
      .y_coord             (req_ch.y_coord),
      .z_coord             (req_ch.z_coord),
      .point_index         (req_ch.point_index),
      .on_boundary         (req_ch.on_boundary),
      .skip_boundary_pairs (skip_ff),
      .radius_squared      (radius_ff),
      .p_valid             (p_valid),
      .p_kind              (p_kind),
      .p_dist              (p_dist),
      .p_index             (p_index),
      .p_keep              (p_keep)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         knn_pkg::ST_RUN: begin
            if (p_valid && p_kind == knn_pkg::KIND_FINISH) state_in = knn_pkg::ST_EMIT;
         end
         knn_pkg::ST_EMIT: begin
            if (out_load && emit_last) state_in = knn_pkg::ST_RUN;
         end
         default: state_in = knn_pkg::ST_RUN;
      endcase
   end

   always_comb begin
      adv         = (state_ff == knn_pkg::ST_RUN);
      emit_step   = (state_ff == knn_pkg::ST_EMIT) && out_load;
      ctrl.clear  = adv && p_valid && p_kind == knn_pkg::KIND_QUERY;
      ctrl.insert = adv && p_valid && p_kind == knn_pkg::KIND_CANDIDATE && p_keep;
      ctrl.rotate = emit_step;
   end

   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= knn_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // slot chain
   logic [MAX_NEIGHBOURS-1:0] valid_vec, active_vec, wrap_vec, hit_vec;
   logic [DW-1:0]             dist_arr  [MAX_NEIGHBOURS];
   logic [INDEX_BITS-1:0]     index_arr [MAX_NEIGHBOURS];

   for (genvar j = 0; j < MAX_NEIGHBOURS; j++) begin : g_cell
      logic                  l_valid, r_valid, h_in;
      logic [DW-1:0]         l_dist, r_dist;
      logic [INDEX_BITS-1:0] l_index, r_index;

      assign active_vec[j] = (8'(j) < k_eff);
      assign wrap_vec[j]   = (8'(j) == (k_eff - 8'd1));

      if (j == 0) begin : g_first
         assign h_in    = 1'b0;
         assign l_valid = 1'b1;
         assign l_dist  = p_dist;
         assign l_index = p_index;
      end else begin : g_inner
         assign h_in    = hit_vec[j-1];
         assign l_valid = valid_vec[j-1];
         assign l_dist  = dist_arr[j-1];
         assign l_index = index_arr[j-1];
      end

      if (j == MAX_NEIGHBOURS - 1) begin : g_last
         assign r_valid = valid_vec[0];
         assign r_dist  = dist_arr[0];
         assign r_index = index_arr[0];
      end else begin : g_mid
         assign r_valid = valid_vec[j+1];
         assign r_dist  = dist_arr[j+1];
         assign r_index = index_arr[j+1];
      end

      knn_cell #(
         .INDEX_BITS (INDEX_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .active      (active_vec[j]),
         .wrap        (wrap_vec[j]),
         .hit_in      (h_in),
         .hit_out     (hit_vec[j]),
         .cand_dist   (p_dist),
         .cand_index  (p_index),
         .left_valid  (l_valid),
         .left_dist   (l_dist),
         .left_index  (l_index),
         .right_valid (r_valid),
         .right_dist  (r_dist),
         .right_index (r_index),
         .head_valid  (valid_vec[0]),
         .head_dist   (dist_arr[0]),
         .head_index  (index_arr[0]),
         .slot_valid  (valid_vec[j]),
         .slot_dist   (dist_arr[j]),
         .slot_index  (index_arr[j])
      );
   end

   // readout: slot 0 goes out, the active ring rotates one place
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         incomplete_ff <= 1'b0;
      end else if (state_ff == knn_pkg::ST_RUN) begin
         cnt_ff        <= '0;
         incomplete_ff <= !(|(wrap_vec & valid_vec));
      end else if (emit_step) begin
         cnt_ff <= emit_last ? '0 : cnt_ff + SLOT_W'(1);
      end
   end

   logic [7:0]                   slot_num_ext;
   logic [IDX_EXT_W-1:0]         head_idx_ext;
   logic [knn_pkg::SLOT_NUM_W-1:0] slot_number_ff;
   logic [knn_pkg::OUT_IDX_W-1:0]  nb_index_ff;
   logic [DW-1:0]                  nb_dist_ff;
   logic                           filled_ff, last_ff, list_inc_ff;

   assign slot_num_ext = 8'(cnt_ff);
   assign head_idx_ext = IDX_EXT_W'(index_arr[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_step) begin
         slot_number_ff <= slot_num_ext[knn_pkg::SLOT_NUM_W-1:0];
         nb_index_ff    <= valid_vec[0] ? head_idx_ext[knn_pkg::OUT_IDX_W-1:0] : '0;
         nb_dist_ff     <= valid_vec[0] ? dist_arr[0] : '0;
         filled_ff      <= valid_vec[0];
         list_inc_ff    <= incomplete_ff;
         last_ff        <= emit_last;
      end
   end

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.slot_number           = slot_number_ff;
   assign rsp_ch.neighbour_index       = nb_index_ff;
   assign rsp_ch.neighbour_distance_sq = nb_dist_ff;
   assign rsp_ch.slot_filled           = filled_ff;
   assign rsp_ch.list_incomplete       = list_inc_ff;
   assign rsp_ch.last_of_list          = last_ff;

   `KNN_ASSERT(a_ctrl_exclusive, !(ctrl.rotate && (ctrl.insert || ctrl.clear)), "rotate overlaps list update")
   `KNN_ASSERT(a_emit_exit, (emit_step && emit_last) |=> (state_ff == knn_pkg::ST_RUN), "readout did not end on last slot")
   `KNN_ASSERT(a_valid_prefix, (state_ff == knn_pkg::ST_RUN) |-> (((valid_vec >> 1) & ~valid_vec) == '0), "filled slots not contiguous")
   `KNN_ASSERT(a_incomplete_hold, ((state_ff == knn_pkg::ST_EMIT) && $past(state_ff == knn_pkg::ST_EMIT)) |-> $stable(incomplete_ff), "incomplete flag changed mid-list")

endmodule

`default_nettype wire
